@@ rtl/dtp_pkg.sv @@
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared widths, character codes, total step codes and the control/status bundles passed
// between the duration parser controller and datapath.
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CALC_W  = 52;
  localparam int unsigned TOTAL_W = 53;

  localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CH_W     = 8'h57;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // total computation steps
  localparam logic [1:0] STEP_WEEKS   = 2'd0;
  localparam logic [1:0] STEP_HOURS   = 2'd1;
  localparam logic [1:0] STEP_MINUTES = 2'd2;
  localparam logic [1:0] STEP_SECONDS = 2'd3;

  // character class flags and accumulator overflow flag from the datapath decoder
  typedef struct packed {
    logic dig;
    logic ovf;
    logic minus;
    logic plus;
    logic p;
    logic t;
    logic w;
    logic d;
    logic h;
    logic m;
    logic s;
  } dtp_status_t;

  typedef struct packed {
    logic       acc_first;
    logic       acc_add;
    logic       acc_clr;
    logic       set_neg;
    logic       st_w;
    logic       st_d;
    logic       st_h;
    logic       st_m;
    logic       st_s;
    logic       calc_en;
    logic [1:0] calc_step;
    logic       load_out;
    logic       clear_all;
  } dtp_cmd_t;

endpackage

@@ rtl/dtp_in_if.sv @@
// ----------------------------------------------------------------------------
// dtp_in_if
// Character stream channel: one text byte per word plus an end-of-string flag.
// ----------------------------------------------------------------------------
interface dtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

@@ rtl/dtp_out_if.sv @@
// ----------------------------------------------------------------------------
// dtp_out_if
// Result channel: sign, the five unit counts and the signed total in seconds.
// ----------------------------------------------------------------------------
interface dtp_out_if;
  logic        valid;
  logic        ready;
  logic        is_forward;
  logic [31:0] week_count;
  logic [31:0] day_count;
  logic [31:0] hour_count;
  logic [31:0] minute_count;
  logic [31:0] second_count;
  logic [52:0] total_secs;

  modport source (output valid, output is_forward, output week_count, output day_count,
                  output hour_count, output minute_count, output second_count,
                  output total_secs, input ready);
  modport sink   (input valid, input is_forward, input week_count, input day_count,
                  input hour_count, input minute_count, input second_count,
                  input total_secs, output ready);
endinterface

@@ rtl/dtp_datapath.sv @@
// ----------------------------------------------------------------------------
// dtp_datapath
// Character decoder, decimal accumulator, unit count registers, shift-add
// total evaluator and the output word register.
// ----------------------------------------------------------------------------
module dtp_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [7:0]               char_code_i,
  input  dtp_pkg::dtp_cmd_t        cmd_i,
  output dtp_pkg::dtp_status_t     status_o,
  output logic                     is_forward_o,
  output logic [31:0]              week_count_o,
  output logic [31:0]              day_count_o,
  output logic [31:0]              hour_count_o,
  output logic [31:0]              minute_count_o,
  output logic [31:0]              second_count_o,
  output logic [52:0]              total_secs_o
);
  import dtp_pkg::*;

  logic [CNT_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   weeks_q, days_q, hours_q, minutes_q, seconds_q;
  logic               fwd_q;
  logic [CALC_W-1:0]  calc_q, calc_d;
  logic [CNT_W-1:0]   digit_val;
  logic [CNT_W+3:0]   acc_x10;
  logic [TOTAL_W-1:0] total_d;

  logic               out_fwd_q;
  logic [CNT_W-1:0]   out_w_q, out_d_q, out_h_q, out_m_q, out_s_q;
  logic [TOTAL_W-1:0] out_total_q;

  // character classes
  always_comb begin
    status_o.dig   = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
    status_o.minus = (char_code_i == CH_MINUS);
    status_o.plus  = (char_code_i == CH_PLUS);
    status_o.p     = (char_code_i == CH_P);
    status_o.t     = (char_code_i == CH_T);
    status_o.w     = (char_code_i == CH_W);
    status_o.d     = (char_code_i == CH_D);
    status_o.h     = (char_code_i == CH_H);
    status_o.m     = (char_code_i == CH_M);
    status_o.s     = (char_code_i == CH_S);
    status_o.ovf   = |acc_x10[CNT_W+3:CNT_W];
  end

  assign digit_val = CNT_W'(char_code_i - CH_ZERO);
  // acc*10 + digit, kept wide enough to see a carry past 32 bits
  assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {4'b0000, digit_val};

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.clear_all || cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (cmd_i.acc_first) begin
      acc_d = digit_val;
    end else if (cmd_i.acc_add) begin
      acc_d = acc_x10[CNT_W-1:0];
    end
  end

  // ((((w*7+d)*24+h)*60+m)*60+s), one step per cycle while calc_en is set, constants as shift-add
  always_comb begin
    case (cmd_i.calc_step)
      STEP_WEEKS:   calc_d = {17'd0, weeks_q, 3'b000} - {20'd0, weeks_q}
                             + {20'd0, days_q};
      STEP_HOURS:   calc_d = {calc_q[CALC_W-5:0], 4'b0000} + {calc_q[CALC_W-4:0], 3'b000}
                             + {20'd0, hours_q};
      STEP_MINUTES: calc_d = {calc_q[CALC_W-7:0], 6'b000000} - {calc_q[CALC_W-3:0], 2'b00}
                             + {20'd0, minutes_q};
      STEP_SECONDS: calc_d = {calc_q[CALC_W-7:0], 6'b000000} - {calc_q[CALC_W-3:0], 2'b00}
                             + {20'd0, seconds_q};
      default:      calc_d = calc_q;
    endcase
  end

  assign total_d = fwd_q ? {1'b0, calc_q} : (TOTAL_W'(0) - {1'b0, calc_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      weeks_q   <= '0;
      days_q    <= '0;
      hours_q   <= '0;
      minutes_q <= '0;
      seconds_q <= '0;
      fwd_q     <= 1'b1;
    end else begin
      acc_q <= acc_d;
      if (cmd_i.clear_all) begin
        weeks_q   <= '0;
        days_q    <= '0;
        hours_q   <= '0;
        minutes_q <= '0;
        seconds_q <= '0;
        fwd_q     <= 1'b1;
      end else begin
        if (cmd_i.st_w) weeks_q   <= acc_q;
        if (cmd_i.st_d) days_q    <= acc_q;
        if (cmd_i.st_h) hours_q   <= acc_q;
        if (cmd_i.st_m) minutes_q <= acc_q;
        if (cmd_i.st_s) seconds_q <= acc_q;
        if (cmd_i.set_neg) fwd_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      calc_q <= calc_d;
    end
    if (cmd_i.load_out) begin
      out_fwd_q   <= fwd_q;
      out_w_q     <= weeks_q;
      out_d_q     <= days_q;
      out_h_q     <= hours_q;
      out_m_q     <= minutes_q;
      out_s_q     <= seconds_q;
      out_total_q <= total_d;
    end
  end

  assign is_forward_o   = out_fwd_q;
  assign week_count_o   = out_w_q;
  assign day_count_o    = out_d_q;
  assign hour_count_o   = out_h_q;
  assign minute_count_o = out_m_q;
  assign second_count_o = out_s_q;
  assign total_secs_o   = out_total_q;

endmodule

@@ rtl/dtp_ctrl.sv @@
// ----------------------------------------------------------------------------
// dtp_ctrl
// Syntax state machine for the duration text and sequencer for the total
// evaluation and result hand-off.
// ----------------------------------------------------------------------------
module dtp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_final_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dtp_pkg::dtp_status_t status_i,
  output dtp_pkg::dtp_cmd_t    cmd_o
);
  import dtp_pkg::*;

  localparam logic [1:0] ST_PARSE = 2'd0;
  localparam logic [1:0] ST_CALC  = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;

  localparam logic [2:0] PH_START       = 3'd0;
  localparam logic [2:0] PH_SIGNED      = 3'd1;
  localparam logic [2:0] PH_DATE_EMPTY  = 3'd2;
  localparam logic [2:0] PH_DATE_DIGITS = 3'd3;
  localparam logic [2:0] PH_AFTER_DAYS  = 3'd4;
  localparam logic [2:0] PH_TIME_EMPTY  = 3'd5;
  localparam logic [2:0] PH_TIME_DIGITS = 3'd6;
  localparam logic [2:0] PH_STOPPED     = 3'd7;

  logic [1:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic [1:0] tstage_q, tstage_d;
  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_PARSE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    phase_d     = phase_q;
    tstage_d    = tstage_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_PARSE: begin
        if (in_fire) begin
          case (phase_q)
            PH_START: begin
              if (status_i.minus) begin
                cmd_o.set_neg = 1'b1;
                phase_d       = PH_SIGNED;
              end else if (status_i.plus) begin
                phase_d = PH_SIGNED;
              end else if (status_i.p) begin
                phase_d = PH_DATE_EMPTY;
              end else begin
                phase_d = PH_STOPPED;
              end
            end
            PH_SIGNED: begin
              phase_d = status_i.p ? PH_DATE_EMPTY : PH_STOPPED;
            end
            PH_DATE_EMPTY: begin
              if (status_i.t) begin
                phase_d = PH_TIME_EMPTY;
              end else if (status_i.dig) begin
                cmd_o.acc_first = 1'b1;
                phase_d         = PH_DATE_DIGITS;
              end else begin
                phase_d = PH_STOPPED;
              end
            end
            PH_DATE_DIGITS: begin
              if (status_i.dig && !status_i.ovf) begin
                cmd_o.acc_add = 1'b1;
              end else begin
                cmd_o.acc_clr = 1'b1;
                phase_d       = PH_STOPPED;
                if (status_i.w) begin
                  cmd_o.st_w = 1'b1;
                end else if (status_i.d) begin
                  cmd_o.st_d = 1'b1;
                  phase_d    = PH_AFTER_DAYS;
                end
              end
            end
            PH_AFTER_DAYS: begin
              phase_d = status_i.t ? PH_TIME_EMPTY : PH_STOPPED;
            end
            PH_TIME_EMPTY: begin
              if (status_i.dig) begin
                cmd_o.acc_first = 1'b1;
                phase_d         = PH_TIME_DIGITS;
              end else begin
                phase_d = PH_STOPPED;
              end
            end
            PH_TIME_DIGITS: begin
              if (status_i.dig && !status_i.ovf) begin
                cmd_o.acc_add = 1'b1;
              end else begin
                cmd_o.acc_clr = 1'b1;
                phase_d       = PH_STOPPED;
                // time units only in the order hours, minutes, seconds
                if (status_i.h && tstage_q == 2'd0) begin
                  cmd_o.st_h = 1'b1;
                  tstage_d   = 2'd1;
                  phase_d    = PH_TIME_EMPTY;
                end else if (status_i.m && tstage_q <= 2'd1) begin
                  cmd_o.st_m = 1'b1;
                  tstage_d   = 2'd2;
                  phase_d    = PH_TIME_EMPTY;
                end else if (status_i.s && tstage_q <= 2'd2) begin
                  cmd_o.st_s = 1'b1;
                  tstage_d   = 2'd3;
                end
              end
            end
            default: phase_d = PH_STOPPED;
          endcase
          if (in_final_i) begin
            state_d = ST_CALC;
            step_d  = STEP_WEEKS;
          end
        end
      end
      ST_CALC: begin
        cmd_o.calc_en   = 1'b1;
        cmd_o.calc_step = step_q;
        step_d          = step_q + 2'd1;
        if (step_q == STEP_SECONDS) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.clear_all = 1'b1;
          out_valid_d     = 1'b1;
          phase_d         = PH_START;
          tstage_d        = 2'd0;
          state_d         = ST_PARSE;
        end
      end
      default: state_d = ST_PARSE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      phase_q     <= PH_START;
      tstage_q    <= 2'd0;
      step_q      <= STEP_WEEKS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      tstage_q    <= tstage_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/duration_text_parser_unit.sv @@
// ----------------------------------------------------------------------------
// duration_text_parser_unit
// Byte-serial calendar duration text parser: unit counts plus signed total
// in seconds, one result word per string.
// ----------------------------------------------------------------------------
//  channel  dir  word contents
//  -------  ---  ---------------------------------------------------------
//  in_i     in   char_code[7:0], final_char
//  out_o    out  is_forward, week/day/hour/minute/second_count[31:0],
//                total_secs[52:0] (two's complement)
//
//  Ordinary characters are taken one per cycle while the parser is in its
//  parse state. After a final character, input is held off while the four
//  shift-add steps of the total evaluator run and the output register is
//  loaded. The load waits while a previous result is still held on out_o;
//  parsing of the next string proceeds while a result waits. Reset is
//  asynchronous, active low, and leaves the parser ready for a new string.
// ----------------------------------------------------------------------------
module duration_text_parser_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtp_in_if.sink    in_i,
  dtp_out_if.source out_o
);
  import dtp_pkg::*;

  dtp_cmd_t    cmd;
  dtp_status_t status;

  dtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_final_i  (in_i.final_char),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dtp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_code_i    (in_i.char_code),
    .cmd_i          (cmd),
    .status_o       (status),
    .is_forward_o   (out_o.is_forward),
    .week_count_o   (out_o.week_count),
    .day_count_o    (out_o.day_count),
    .hour_count_o   (out_o.hour_count),
    .minute_count_o (out_o.minute_count),
    .second_count_o (out_o.second_count),
    .total_secs_o   (out_o.total_secs)
  );

  // end of string blocks input while the total is evaluated
  a_final_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.final_char |=> !in_i.ready)
    else $error("input taken right after end of string");

  a_fwd_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_forward |-> !out_o.total_secs[52])
    else $error("positive duration with negative total");

  a_back_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.is_forward |-> out_o.total_secs[52] || out_o.total_secs == '0)
    else $error("negative duration with positive total");

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for duration_text_parser_unit. Directed duration strings are
// followed by random well-formed, broken and noise strings, sent one
// character per word. Each accepted word steps a local parser model. Each
// result word is compared field by field with the oldest expected result.
// Both channels idle at random, and one long receiver hold-off fills the
// block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  localparam int unsigned RAND_CHARS  = 1150;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // next time unit still allowed
  localparam logic [1:0] TU_HOURS   = 2'd0;
  localparam logic [1:0] TU_MINUTES = 2'd1;
  localparam logic [1:0] TU_SECONDS = 2'd2;
  localparam logic [1:0] TU_NONE    = 2'd3;

  typedef enum logic [2:0] {
    P_SIGN_OR_P,
    P_AFTER_SIGN,
    P_DATE_NONE,
    P_DATE_NUM,
    P_DAYS_DONE,
    P_TIME_NONE,
    P_TIME_NUM,
    P_HALT
  } parse_phase_e;

  typedef struct packed {
    logic        is_fwd;
    logic [31:0] weeks;
    logic [31:0] days;
    logic [31:0] hours;
    logic [31:0] minutes;
    logic [31:0] seconds;
    logic [52:0] total;
  } dur_result_t;

  typedef struct {
    string       txt;
    bit          typed;
    dur_result_t exp_res;
  } directed_row_t;

  localparam dur_result_t ZERO_FWD = '{is_fwd: 1'b1, default: '0};
  localparam dur_result_t ZERO_NEG = '{is_fwd: 1'b0, default: '0};

  logic clk_i;
  logic rst_ni;

  dtp_in_if  in_if ();
  dtp_out_if out_if ();

  duration_text_parser_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // parser model state
  parse_phase_e ph;
  logic [1:0]   tstage;
  logic         fwd;
  logic [31:0]  acc;
  logic [31:0]  weeks, days, hours, minutes, seconds;

  dur_result_t  dur_q[$];
  logic [7:0]   text_q[$];
  bit           word_typed;
  dur_result_t  word_exp;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  bit           rx_hold;
  bit           hold_go;
  int unsigned  err_count;
  int unsigned  cycles;
  directed_row_t directed_rows[7];

  function automatic void clear_parser();
    ph      = P_SIGN_OR_P;
    tstage  = TU_HOURS;
    fwd     = 1'b1;
    acc     = '0;
    weeks   = '0;
    days    = '0;
    hours   = '0;
    minutes = '0;
    seconds = '0;
  endfunction

  // Steps the model by one character; returns 1 with the result on a final one.
  function automatic bit parse_char(input logic [7:0] c, input logic fin,
                                    output dur_result_t res);
    bit          is_dig;
    logic [63:0] v;
    logic [63:0] t;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    v = acc * 64'd10 + 64'(c - CH_ZERO);
    res = '0;
    case (ph)
      P_SIGN_OR_P: begin
        if (c == CH_MINUS) begin
          fwd = 1'b0;
          ph  = P_AFTER_SIGN;
        end else if (c == CH_PLUS) begin
          ph = P_AFTER_SIGN;
        end else if (c == CH_P) begin
          ph = P_DATE_NONE;
        end else begin
          ph = P_HALT;
        end
      end
      P_AFTER_SIGN: ph = (c == CH_P) ? P_DATE_NONE : P_HALT;
      P_DATE_NONE: begin
        if (c == CH_T) begin
          ph = P_TIME_NONE;
        end else if (is_dig) begin
          acc = 32'(c - CH_ZERO);
          ph  = P_DATE_NUM;
        end else begin
          ph = P_HALT;
        end
      end
      P_DATE_NUM: begin
        if (is_dig) begin
          if (v > 64'hFFFF_FFFF) ph = P_HALT;
          else acc = v[31:0];
        end else if (c == CH_W) begin
          weeks = acc;
          ph    = P_HALT;
        end else if (c == CH_D) begin
          days = acc;
          ph   = P_DAYS_DONE;
        end else begin
          ph = P_HALT;
        end
        if (ph != P_DATE_NUM) acc = '0;
      end
      P_DAYS_DONE: ph = (c == CH_T) ? P_TIME_NONE : P_HALT;
      P_TIME_NONE: begin
        if (is_dig) begin
          acc = 32'(c - CH_ZERO);
          ph  = P_TIME_NUM;
        end else begin
          ph = P_HALT;
        end
      end
      P_TIME_NUM: begin
        if (is_dig) begin
          if (v > 64'hFFFF_FFFF) ph = P_HALT;
          else acc = v[31:0];
        end else if (c == CH_H && tstage <= TU_HOURS) begin
          hours  = acc;
          tstage = TU_MINUTES;
          ph     = P_TIME_NONE;
        end else if (c == CH_M && tstage <= TU_MINUTES) begin
          minutes = acc;
          tstage  = TU_SECONDS;
          ph      = P_TIME_NONE;
        end else if (c == CH_S && tstage <= TU_SECONDS) begin
          seconds = acc;
          tstage  = TU_NONE;
          ph      = P_HALT;
        end else begin
          ph = P_HALT;
        end
        if (ph != P_TIME_NUM) acc = '0;
      end
      default: ph = P_HALT;
    endcase
    if (!fin) return 1'b0;
    t = 64'(weeks) * 64'd7 + 64'(days);
    t = t * 64'd24 + 64'(hours);
    t = t * 64'd60 + 64'(minutes);
    t = t * 64'd60 + 64'(seconds);
    if (!fwd) t = -t;
    res.is_fwd  = fwd;
    res.weeks   = weeks;
    res.days    = days;
    res.hours   = hours;
    res.minutes = minutes;
    res.seconds = seconds;
    res.total   = t[52:0];
    clear_parser();
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // clock, cycle limit
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // accepted words on both channels, sampled before the edge's updates
  always @(posedge clk_i) begin
    dur_result_t got;
    dur_result_t want;
    dur_result_t pred;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.is_forward, out_if.week_count, out_if.day_count,
                out_if.hour_count, out_if.minute_count, out_if.second_count,
                out_if.total_secs};
        if (dur_q.size() == 0) begin
          $error("result word with no expected result waiting");
          err_count++;
        end else begin
          want = dur_q.pop_front();
          check_field("is_forward", 64'(want.is_fwd), 64'(got.is_fwd));
          check_field("week_count", 64'(want.weeks), 64'(got.weeks));
          check_field("day_count", 64'(want.days), 64'(got.days));
          check_field("hour_count", 64'(want.hours), 64'(got.hours));
          check_field("minute_count", 64'(want.minutes), 64'(got.minutes));
          check_field("second_count", 64'(want.seconds), 64'(got.seconds));
          check_field("total_secs", 64'(want.total), 64'(got.total));
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (parse_char(in_if.char_code, in_if.final_char, pred))
          dur_q.push_back(word_typed ? word_exp : pred);
      end
    end
  end

  // receiver
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= rst_ni && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering words
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic send_word(input logic [7:0] c, input logic fin, input bit typed,
                           input dur_result_t exp_res);
    bit rdy;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.char_code  <= c;
    in_if.final_char <= fin;
    word_typed       <= typed;
    word_exp         <= exp_res;
    // ready is stable by the falling edge
    do begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic send_text(input bit typed, input dur_result_t exp_res);
    foreach (text_q[k])
      send_word(text_q[k], k == text_q.size() - 1, typed, exp_res);
  endtask

  task automatic append_number();
    logic [63:0] v;
    string       s;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45)      v = 64'($urandom_range(9));
    else if (r < 75) v = 64'($urandom_range(999, 10));
    else if (r < 87) v = 64'($urandom());
    else if (r < 92) v = 64'hFFFF_FFFF;
    else if (r < 97) v = 64'h1_0000_0000 + 64'($urandom_range(9));
    else             v = 64'd10_000_000_000 + 64'($urandom());
    s = $sformatf("%0d", v);
    if ($urandom_range(9) == 0) s = {"00", s};
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic build_random_text();
    string       pool;
    int unsigned r;
    int unsigned n;
    int unsigned pos;
    int unsigned units;
    logic [7:0]  c;
    pool = "PTWDHMS+-0123456789 ";
    text_q.delete();
    r = $urandom_range(99);
    if (r < 10) begin
      n = $urandom_range(6, 1);
      repeat (n) text_q.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(5);
      if (n == 0) text_q.push_back(CH_MINUS);
      else if (n == 1) text_q.push_back(CH_PLUS);
      text_q.push_back(CH_P);
      if ($urandom_range(3) == 0) begin
        append_number();
        text_q.push_back(CH_W);
      end else begin
        units = $urandom_range(15);
        if (units[3] || units[2:0] == 3'b000) begin
          append_number();
          text_q.push_back(CH_D);
        end
        if (units[2:0] != 3'b000 || $urandom_range(9) == 0) begin
          text_q.push_back(CH_T);
          if (units[0]) begin append_number(); text_q.push_back(CH_H); end
          if (units[1]) begin append_number(); text_q.push_back(CH_M); end
          if (units[2]) begin append_number(); text_q.push_back(CH_S); end
        end
      end
      // broken strings: overwrite, insert, drop or trail a character
      if (r >= 78) begin
        c = ($urandom_range(1) == 0) ? 8'(pool[$urandom_range(pool.len() - 1)])
                                     : 8'($urandom_range(255));
        pos = $urandom_range(text_q.size() - 1);
        case ($urandom_range(3))
          0: text_q[pos] = c;
          1: text_q.insert(pos, c);
          2: text_q.delete(pos);
          default: text_q.push_back(c);
        endcase
        if (text_q.size() == 0) text_q.push_back(c);
      end
    end
  endtask

  initial begin
    int unsigned rand_chars;
    string       txt;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.char_code  <= '0;
    in_if.final_char <= 1'b0;
    word_typed       <= 1'b0;
    word_exp         <= '0;
    tx_idle_pct = 15;
    rx_idle_pct = 52;
    hold_go     = 1'b0;
    err_count   = 0;
    cycles      = 0;
    clear_parser();

    directed_rows[0] = '{"P", 1'b1, ZERO_FWD};
    directed_rows[1] = '{"-P0D", 1'b1, ZERO_NEG};        // negative zero
    directed_rows[2] = '{"PW", 1'b1, ZERO_FWD};          // unit with no number
    directed_rows[3] = '{"\377", 1'b1, ZERO_FWD};
    directed_rows[4] = '{"P4294967295W", 1'b0, ZERO_FWD};
    directed_rows[5] = '{"+PT1M2H", 1'b0, ZERO_FWD};     // hours after minutes
    directed_rows[6] = '{"P1DT", 1'b0, ZERO_FWD};        // nothing after T

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      txt = directed_rows[i].txt;
      text_q.delete();
      for (int j = 0; j < txt.len(); j++) text_q.push_back(txt[j]);
      send_text(directed_rows[i].typed, directed_rows[i].exp_res);
    end

    hold_go    = 1'b1;
    rand_chars = 0;
    while (rand_chars < RAND_CHARS) begin
      if (rand_chars >= 2 * RAND_CHARS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (rand_chars >= RAND_CHARS / 3) begin
        tx_idle_pct = 52;
        rx_idle_pct = 15;
      end
      build_random_text();
      rand_chars += text_q.size();
      send_text(1'b0, ZERO_FWD);
    end
    in_if.valid <= 1'b0;

    wait (dur_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0 && dur_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dtp_pkg.sv
rtl/dtp_in_if.sv
rtl/dtp_out_if.sv
rtl/dtp_datapath.sv
rtl/dtp_ctrl.sv
rtl/duration_text_parser_unit.sv
test/tb.sv
